// ----- sv/crc16fp_pkg.sv -----
`default_nettype none

package crc16fp_pkg;

    // CRC-16-CCITT (false): MSB first, no reflection, no final xor.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Header length in bytes: start, type, flags, sequence, length low, length high.
    localparam logic [15:0] HEADER_BYTES = 16'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  START_MARKER_RST = 8'd170;
    localparam logic [7:0]  END_MARKER_RST   = 8'd85;
    localparam logic [15:0] MAX_LEN_RST      = 16'd1024;

    // Status codes reported with each result.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_GOOD     = 2'd1;
    localparam logic [1:0] ST_FORMAT   = 2'd2;
    localparam logic [1:0] ST_CRC_FAIL = 2'd3;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HEADER  = 6'b000010,
        PH_PAYLOAD = 6'b000100,
        PH_CRC     = 6'b001000,
        PH_END     = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

// ----- sv/crc16fp_crc_byte.sv -----
`default_nettype none

// Folds one byte into a CRC-16 remainder, eight bit steps unrolled.
module crc16fp_crc_byte (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ crc16fp_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ----- sv/crc16_frame_parser_core.sv -----
`default_nettype none

// Byte-stream frame parser with a CRC-16-CCITT check. One received byte enters
// per transaction on the s_ channel and every byte yields exactly one result
// transaction on the m_ channel, in order. A frame is the start marker, type,
// flags, sequence, a little-endian 16-bit payload length, the payload, a
// little-endian CRC and the end marker. The CRC (initial 0xFFFF, polynomial
// 0x1021) covers the header, start marker included, and the payload. Payload
// bytes are streamed out with m_payload_valid set; the frame_* outputs show the
// header fields as they stand after the byte, and m_computed_crc the running
// CRC. m_status reports 1 for a good frame, 2 for a length above the limit or a
// bad end marker, and 3 for a CRC mismatch. After an error, bytes are ignored
// until a start marker arrives; a start marker inside a frame is plain data.
// The block sustains one byte per clock cycle while m_ready holds: a byte is
// registered in the input register and is then folded into the parser state and
// result register in one pass, whose path is set by the eight-step CRC update.
// The result of an accepted byte is offered on the m_ channel from the result
// register, after the input register. The configuration registers (0: start
// marker, 1: end marker, 2: maximum payload length) are written through the
// cfg_ channel, which is always ready, and should be written only while no
// byte is in flight.
module crc16_frame_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_status,
    output logic             m_payload_valid,
    output logic      [7:0]  m_payload_byte,
    output logic      [7:0]  m_frame_type,
    output logic      [7:0]  m_frame_flags,
    output logic      [7:0]  m_frame_seq,
    output logic      [15:0] m_frame_len,
    output logic      [15:0] m_computed_crc,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [15:0] max_len_reg;

    // Input stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // Parser state.
    crc16fp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] expected_len_reg, expected_len_next;
    logic [7:0]  hdr_type_reg, hdr_type_next;
    logic [7:0]  hdr_flags_reg, hdr_flags_next;
    logic [7:0]  hdr_seq_reg, hdr_seq_next;
    logic [15:0] hdr_len_reg, hdr_len_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] received_crc_reg, received_crc_next;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_status_reg, status_next;
    logic        m_pvalid_reg, pvalid_next;
    logic [7:0]  m_pbyte_reg, pbyte_next;

    logic        advance;
    logic        in_frame;
    logic [15:0] crc_seed;
    logic [15:0] crc_stepped;
    logic [15:0] count_inc;

    // The result register moves whenever it is empty or being drained, and
    // the input register refills in the same cycle it hands its byte over.
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Outside a frame the CRC restarts from its seed with the start marker.
    assign in_frame = (phase_reg == crc16fp_pkg::PH_HEADER) ||
                      (phase_reg == crc16fp_pkg::PH_PAYLOAD);
    assign crc_seed = in_frame ? running_crc_reg : crc16fp_pkg::CRC_INIT;

    crc16fp_crc_byte u_crc (
        .crc_in  (crc_seed),
        .data_in (in_byte_reg),
        .crc_out (crc_stepped)
    );

    assign count_inc = byte_count_reg + 16'd1;

    always_comb begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        expected_len_next = expected_len_reg;
        hdr_type_next     = hdr_type_reg;
        hdr_flags_next    = hdr_flags_reg;
        hdr_seq_next      = hdr_seq_reg;
        hdr_len_next      = hdr_len_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        status_next       = crc16fp_pkg::ST_NONE;
        pvalid_next       = 1'b0;
        pbyte_next        = 8'h00;

        case (phase_reg)
            crc16fp_pkg::PH_HEADER: begin
                running_crc_next = crc_stepped;
                case (byte_count_reg)
                    16'd1: hdr_type_next  = in_byte_reg;
                    16'd2: hdr_flags_next = in_byte_reg;
                    16'd3: hdr_seq_next   = in_byte_reg;
                    16'd4: hdr_len_next   = {hdr_len_reg[15:8], in_byte_reg};
                    16'd5: hdr_len_next   = {in_byte_reg, hdr_len_reg[7:0]};
                    default: ;
                endcase
                byte_count_next = count_inc;
                if (count_inc >= crc16fp_pkg::HEADER_BYTES) begin
                    byte_count_next = 16'd0;
                    if (hdr_len_next > max_len_reg) begin
                        phase_next  = crc16fp_pkg::PH_ERROR;
                        status_next = crc16fp_pkg::ST_FORMAT;
                    end else if (hdr_len_next != 16'd0) begin
                        phase_next        = crc16fp_pkg::PH_PAYLOAD;
                        expected_len_next = hdr_len_next;
                    end else begin
                        phase_next = crc16fp_pkg::PH_CRC;
                    end
                end
            end
            crc16fp_pkg::PH_PAYLOAD: begin
                running_crc_next = crc_stepped;
                pvalid_next      = 1'b1;
                pbyte_next       = in_byte_reg;
                byte_count_next  = count_inc;
                if (count_inc >= expected_len_reg) begin
                    phase_next      = crc16fp_pkg::PH_CRC;
                    byte_count_next = 16'd0;
                end
            end
            crc16fp_pkg::PH_CRC: begin
                if (byte_count_reg == 16'd0) begin
                    received_crc_next = {received_crc_reg[15:8], in_byte_reg};
                    byte_count_next   = 16'd1;
                end else begin
                    received_crc_next = {in_byte_reg, received_crc_reg[7:0]};
                    phase_next        = crc16fp_pkg::PH_END;
                end
            end
            crc16fp_pkg::PH_END: begin
                if (in_byte_reg == end_marker_reg) begin
                    if (running_crc_reg == received_crc_reg) begin
                        phase_next  = crc16fp_pkg::PH_IDLE;
                        status_next = crc16fp_pkg::ST_GOOD;
                    end else begin
                        phase_next  = crc16fp_pkg::PH_ERROR;
                        status_next = crc16fp_pkg::ST_CRC_FAIL;
                    end
                end else begin
                    phase_next  = crc16fp_pkg::PH_ERROR;
                    status_next = crc16fp_pkg::ST_FORMAT;
                end
            end
            default: begin
                // Idle and error phases both hunt for the start marker.
                if (in_byte_reg == start_marker_reg) begin
                    phase_next        = crc16fp_pkg::PH_HEADER;
                    byte_count_next   = 16'd1;
                    expected_len_next = 16'd0;
                    running_crc_next  = crc_stepped;
                end
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= crc16fp_pkg::START_MARKER_RST;
            end_marker_reg   <= crc16fp_pkg::END_MARKER_RST;
            max_len_reg      <= crc16fp_pkg::MAX_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                crc16fp_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data[7:0];
                crc16fp_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data[7:0];
                crc16fp_pkg::CFG_MAX_LEN:      max_len_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Parser state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= crc16fp_pkg::PH_IDLE;
            byte_count_reg   <= 16'd0;
            expected_len_reg <= 16'd0;
            hdr_type_reg     <= 8'd0;
            hdr_flags_reg    <= 8'd0;
            hdr_seq_reg      <= 8'd0;
            hdr_len_reg      <= 16'd0;
            running_crc_reg  <= crc16fp_pkg::CRC_INIT;
            received_crc_reg <= 16'd0;
            m_valid_reg      <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                expected_len_reg <= expected_len_next;
                hdr_type_reg     <= hdr_type_next;
                hdr_flags_reg    <= hdr_flags_next;
                hdr_seq_reg      <= hdr_seq_next;
                hdr_len_reg      <= hdr_len_next;
                running_crc_reg  <= running_crc_next;
                received_crc_reg <= received_crc_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            m_status_reg <= status_next;
            m_pvalid_reg <= pvalid_next;
            m_pbyte_reg  <= pbyte_next;
        end
    end

    // Header fields and the running CRC only change when a result is loaded,
    // so they stand as the result's frame fields directly.
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_payload_valid = m_pvalid_reg;
    assign m_payload_byte  = m_pbyte_reg;
    assign m_frame_type    = hdr_type_reg;
    assign m_frame_flags   = hdr_flags_reg;
    assign m_frame_seq     = hdr_seq_reg;
    assign m_frame_len     = hdr_len_reg;
    assign m_computed_crc  = running_crc_reg;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import crc16fp_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung. The longest
    // legal quiet stretch is the forced receiver hold-off.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic        pvalid;
        logic [7:0]  pbyte;
        logic [7:0]  ftype;
        logic [7:0]  fflags;
        logic [7:0]  fseq;
        logic [15:0] flen;
        logic [15:0] crc;
    } parse_result_t;

    typedef enum {FRAME_OK, FRAME_BAD_CRC, FRAME_BAD_END, FRAME_TOO_LONG} frame_fault_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_frame_type;
    logic [7:0]  m_frame_flags;
    logic [7:0]  m_frame_seq;
    logic [15:0] m_frame_len;
    logic [15:0] m_computed_crc;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'h0000;

    crc16_frame_parser_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_payload_valid (m_payload_valid),
        .m_payload_byte  (m_payload_byte),
        .m_frame_type    (m_frame_type),
        .m_frame_flags   (m_frame_flags),
        .m_frame_seq     (m_frame_seq),
        .m_frame_len     (m_frame_len),
        .m_computed_crc  (m_computed_crc),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Bytes waiting to be sent, and parser results waiting to come out.
    logic [7:0]    rx_pending [$];
    parse_result_t result_q [$];

    // Handshake outcomes of the last rising edge, read by the drivers at the falling edge.
    bit s_acc = 1'b0;
    bit cfg_acc = 1'b0;

    int n_in = 0;
    int n_out = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    // Register values the stimulus generator builds frames for.
    logic [7:0]  gen_start = START_MARKER_RST;
    logic [7:0]  gen_end = END_MARKER_RST;
    logic [15:0] gen_max = MAX_LEN_RST;

    // Parser mirror: configuration and state, updated on accepted transactions.
    logic [7:0]  cur_start, cur_end;
    logic [15:0] cur_max;
    phase_t      ph;
    logic [15:0] cnt, exp_len, h_len, run_crc, rcv_crc;
    logic [7:0]  h_type, h_flags, h_seq;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        return x;
    endfunction

    // Advances the parser mirror by one byte and returns the result it must produce.
    function automatic parse_result_t parse_byte(input logic [7:0] b);
        parse_result_t r;
        r = '0;
        case (ph)
            PH_HEADER: begin
                run_crc = crc_next(run_crc, b);
                case (cnt)
                    16'd1: h_type = b;
                    16'd2: h_flags = b;
                    16'd3: h_seq = b;
                    16'd4: h_len[7:0] = b;
                    16'd5: h_len[15:8] = b;
                    default: ;
                endcase
                cnt = cnt + 16'd1;
                if (cnt >= HEADER_BYTES) begin
                    cnt = 16'd0;
                    if (h_len > cur_max) begin
                        ph = PH_ERROR;
                        r.status = ST_FORMAT;
                    end else if (h_len != 16'd0) begin
                        ph = PH_PAYLOAD;
                        exp_len = h_len;
                    end else begin
                        ph = PH_CRC;
                    end
                end
            end
            PH_PAYLOAD: begin
                run_crc = crc_next(run_crc, b);
                r.pvalid = 1'b1;
                r.pbyte = b;
                cnt = cnt + 16'd1;
                if (cnt >= exp_len) begin
                    ph = PH_CRC;
                    cnt = 16'd0;
                end
            end
            PH_CRC: begin
                if (cnt == 16'd0) begin
                    rcv_crc[7:0] = b;
                    cnt = 16'd1;
                end else begin
                    rcv_crc[15:8] = b;
                    ph = PH_END;
                end
            end
            PH_END: begin
                if (b != cur_end) begin
                    ph = PH_ERROR;
                    r.status = ST_FORMAT;
                end else if (run_crc == rcv_crc) begin
                    ph = PH_IDLE;
                    r.status = ST_GOOD;
                end else begin
                    ph = PH_ERROR;
                    r.status = ST_CRC_FAIL;
                end
            end
            default: begin
                // Idle and error phases both wait for a start marker.
                if (b == cur_start) begin
                    ph = PH_HEADER;
                    cnt = 16'd1;
                    exp_len = 16'd0;
                    run_crc = crc_next(CRC_INIT, b);
                end
            end
        endcase
        r.ftype = h_type;
        r.fflags = h_flags;
        r.fseq = h_seq;
        r.flen = h_len;
        r.crc = run_crc;
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; none at all while calm.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Monitor: tracks every accepted transaction, predicts on input and checks on output.
    always @(posedge aclk) begin : check_results
        parse_result_t want, got;
        bit s_fire, m_fire, c_fire;
        if (!aresetn) begin
            s_acc <= 1'b0;
            cfg_acc <= 1'b0;
            cur_start = START_MARKER_RST;
            cur_end = END_MARKER_RST;
            cur_max = MAX_LEN_RST;
            ph = PH_IDLE;
            cnt = 16'd0;
            exp_len = 16'd0;
            h_type = 8'h00;
            h_flags = 8'h00;
            h_seq = 8'h00;
            h_len = 16'd0;
            run_crc = CRC_INIT;
            rcv_crc = 16'd0;
        end else begin
            s_fire = s_valid && s_ready;
            m_fire = m_valid && m_ready;
            c_fire = cfg_valid && cfg_ready;
            s_acc <= s_fire;
            cfg_acc <= c_fire;
            if (c_fire) begin
                case (cfg_index)
                    CFG_START_MARKER: cur_start = cfg_data[7:0];
                    CFG_END_MARKER:   cur_end = cfg_data[7:0];
                    CFG_MAX_LEN:      cur_max = cfg_data;
                    default: ;
                endcase
            end
            if (s_fire) begin
                result_q.push_back(parse_byte(s_rx_byte));
                n_in++;
            end
            if (m_fire) begin
                got = {m_status, m_payload_valid, m_payload_byte, m_frame_type,
                       m_frame_flags, m_frame_seq, m_frame_len, m_computed_crc};
                if (result_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("result %0d arrived with nothing expected", n_out);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status || got.pvalid !== want.pvalid ||
                        got.pbyte !== want.pbyte || got.ftype !== want.ftype ||
                        got.fflags !== want.fflags || got.fseq !== want.fseq ||
                        got.flen !== want.flen || got.crc !== want.crc) begin
                        if (mismatches < 10) begin
                            $write("result %0d mismatch (expected/actual): status %0d/%0d",
                                   n_out, want.status, got.status);
                            $write(" pvalid %0d/%0d byte %h/%h type %h/%h flags %h/%h",
                                   want.pvalid, got.pvalid, want.pbyte, got.pbyte,
                                   want.ftype, got.ftype, want.fflags, got.fflags);
                            $display(" seq %h/%h len %h/%h crc %h/%h",
                                     want.fseq, got.fseq, want.flen, got.flen,
                                     want.crc, got.crc);
                        end
                        mismatches++;
                    end
                end
                n_out++;
            end
            if (s_fire || m_fire || c_fire)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Byte driver: holds each byte until it is accepted, then waits out a random gap.
    int s_gap = 0;
    int s_calm = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_calm != 0)
                s_calm <= s_calm - 1;
            else if ($urandom_range(0, 299) == 0)
                s_calm <= $urandom_range(100, 300);
            if (!s_valid || s_acc) begin
                if (s_gap != 0) begin
                    s_valid <= 1'b0;
                    s_gap <= s_gap - 1;
                end else if (rx_pending.size() != 0) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= rx_pending.pop_front();
                    s_gap <= pick_gap(s_calm != 0);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off while plenty of bytes are
    // still queued, so the block fills up and has to push back on its input.
    int  m_gap = 0;
    int  m_calm = 0;
    int  m_hold = 0;
    bit  hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_calm != 0)
                m_calm <= m_calm - 1;
            else if ($urandom_range(0, 299) == 0)
                m_calm <= $urandom_range(100, 300);
            if (m_hold != 0) begin
                m_ready <= 1'b0;
                m_hold <= m_hold - 1;
            end else if (!hold_done && n_in >= 300 && rx_pending.size() > 40) begin
                m_ready <= 1'b0;
                m_hold <= HOLD_OFF_CYCLES - 1;
                hold_done <= 1'b1;
            end else if (m_gap != 0) begin
                m_ready <= 1'b0;
                m_gap <= m_gap - 1;
            end else begin
                m_ready <= 1'b1;
                m_gap <= pick_gap(m_calm != 0);
            end
        end
    end

    // Queues one frame for the current markers. A payload byte is fill when fill is not
    // negative, else random with the start marker mixed in. A too-long frame stops after
    // the header and is followed by a few bytes that the error phase must ignore.
    task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] fflags,
                               input logic [7:0] fseq, input logic [15:0] len,
                               input int fill, input frame_fault_t fault);
        logic [15:0] crc;
        logic [7:0]  b;
        logic [7:0]  hdr [6];
        hdr = '{gen_start, ftype, fflags, fseq, len[7:0], len[15:8]};
        crc = CRC_INIT;
        foreach (hdr[i]) begin
            rx_pending.push_back(hdr[i]);
            crc = crc_next(crc, hdr[i]);
        end
        if (fault == FRAME_TOO_LONG) begin
            repeat ($urandom_range(1, 3)) begin
                b = $urandom_range(0, 255);
                if (b == gen_start)
                    b = b ^ 8'h01;
                rx_pending.push_back(b);
            end
        end else begin
            for (int i = 0; i < len; i++) begin
                if (fill >= 0)
                    b = fill[7:0];
                else if ($urandom_range(0, 15) == 0)
                    b = gen_start;
                else
                    b = $urandom_range(0, 255);
                rx_pending.push_back(b);
                crc = crc_next(crc, b);
            end
            if (fault == FRAME_BAD_CRC)
                crc = crc ^ $urandom_range(1, 65535);
            rx_pending.push_back(crc[7:0]);
            rx_pending.push_back(crc[15:8]);
            b = gen_end;
            if (fault == FRAME_BAD_END)
                b = b ^ $urandom_range(1, 255);
            rx_pending.push_back(b);
        end
    endtask

    // Mostly well-formed frames of small size, with broken frames and line noise between.
    task automatic queue_random_traffic(input int n_bytes);
        int           target, r;
        logic [15:0]  len;
        logic [7:0]   b;
        frame_fault_t fault;
        target = rx_pending.size() + n_bytes;
        while (rx_pending.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                fault = FRAME_OK;
            else if (r < 80)
                fault = FRAME_BAD_CRC;
            else if (r < 90)
                fault = FRAME_BAD_END;
            else
                fault = FRAME_TOO_LONG;
            // No length can exceed a limit of 0xFFFF.
            if (fault == FRAME_TOO_LONG && gen_max == 16'hFFFF)
                fault = FRAME_BAD_CRC;
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(0, 8);
            else if (r < 90)
                len = $urandom_range(9, 40);
            else if (r < 99)
                len = $urandom_range(41, 200);
            else
                len = $urandom_range(400, 1000);
            if (len > gen_max)
                len = gen_max;
            if (gen_max <= 200 && $urandom_range(0, 9) == 0)
                len = gen_max;
            if (fault == FRAME_TOO_LONG) begin
                if ($urandom_range(0, 3) == 0)
                    len = gen_max + 16'd1;
                else
                    len = $urandom_range(gen_max + 1, 65535);
            end
            queue_frame($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), len, -1, fault);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    b = $urandom_range(0, 255);
                    if (b == gen_start)
                        b = b ^ 8'h01;
                    rx_pending.push_back(b);
                end
            end
        end
    endtask

    // Returns at a falling edge once no byte is queued, offered or awaiting its result,
    // and once the block's input and result registers have settled.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (rx_pending.size() != 0 || s_valid || result_q.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    // Writes all three registers back to back; must be called at a falling edge. The
    // unused upper byte of the marker writes carries random bits.
    task automatic set_config(input logic [7:0] sm, input logic [7:0] em,
                              input logic [15:0] ml);
        logic [1:0]  ids [3];
        logic [15:0] vals [3];
        logic [7:0]  hi0, hi1;
        hi0 = $urandom_range(0, 255);
        hi1 = $urandom_range(0, 255);
        ids = '{CFG_START_MARKER, CFG_END_MARKER, CFG_MAX_LEN};
        vals = '{{hi0, sm}, {hi1, em}, ml};
        for (int k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= ids[k];
            cfg_data <= vals[k];
            @(negedge aclk);
            while (!cfg_acc)
                @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        gen_start = sm;
        gen_end = em;
        gen_max = ml;
    endtask

    initial begin
        logic [7:0]  sm, em;
        logic [15:0] ml;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset settings: idle noise, a good zero-length frame, a
        // length at the field's maximum above the limit with bytes the error phase drops,
        // and a one-byte payload equal to the start marker with a bad CRC.
        rx_pending.push_back(8'h00);
        queue_frame(8'hFF, 8'h00, 8'h80, 16'h0000, -1, FRAME_OK);
        queue_frame(8'h01, 8'h7F, 8'h02, 16'hFFFF, -1, FRAME_TOO_LONG);
        queue_frame(8'h02, 8'h5A, 8'h03, 16'h0001, START_MARKER_RST, FRAME_BAD_CRC);
        wait_idle();

        // Extreme settings first, then random ones with the reset values again among them.
        set_config(8'h00, 8'hFF, 16'h0000);
        queue_random_traffic(150);
        wait_idle();

        set_config(8'hFF, 8'h00, 16'hFFFF);
        queue_random_traffic(300);
        wait_idle();

        sm = $urandom_range(0, 255);
        em = $urandom_range(0, 255);
        ml = $urandom_range(0, 64);
        set_config(sm, em, ml);
        queue_random_traffic(250);
        wait_idle();

        set_config(START_MARKER_RST, END_MARKER_RST, MAX_LEN_RST);
        queue_random_traffic(300);
        wait_idle();

        sm = $urandom_range(0, 255);
        em = $urandom_range(0, 255);
        ml = $urandom_range(0, 65535);
        set_config(sm, em, ml);
        queue_random_traffic(250);
        wait_idle();

        sm = $urandom_range(0, 255);
        em = $urandom_range(0, 255);
        ml = $urandom_range(0, 16);
        set_config(sm, em, ml);
        queue_random_traffic(250);
        wait_idle();

        repeat (10) @(negedge aclk);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/crc16fp_pkg.sv
sv/crc16fp_crc_byte.sv
sv/crc16_frame_parser_core.sv
test/tb.sv
